@@ hdl/e2utc_pkg.sv @@
// Shared types, constants and microcode ROM for the epoch-to-UTC date converter.
// No dependencies; imported by epoch_seconds_to_utc_date.
`timescale 1ns / 1ps

package e2utc_pkg;

  localparam int unsigned SecW   = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned YearW  = 8;
  localparam int unsigned YdayW  = 9;
  localparam int unsigned MonW   = 4;
  localparam int unsigned MdayW  = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned PcW    = 4;
  localparam int unsigned CntW   = 4;

  localparam logic [SecW-1:0]  SecPerDay  = 32'd86400;
  localparam logic [SecW-1:0]  SecPerHour = 32'd3600;
  localparam logic [SecW-1:0]  SecPerMin  = 32'd60;
  localparam logic [YearW-1:0] FirstYear  = 8'd70;    // 1970 - 1900
  localparam logic [YearW-1:0] Year2100   = 8'd200;
  localparam logic [MonW-1:0]  LastMonth  = 4'd11;
  localparam logic [WdayW-1:0] DaysPerWk  = 3'd7;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_DSTEP,
    OP_SAVE_DAYS,
    OP_SAVE_HOUR,
    OP_SAVE_MIN,
    OP_YSTEP,
    OP_SAVE_YDAY,
    OP_MSTEP,
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } dsel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_LOAD,
    CNT_DEC
  } cnt_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_IDLE,
    C_CNT_NZ,
    C_YGE,
    C_MGE
  } cond_e;

  typedef struct packed {
    op_e             op;
    dsel_e           dsel;
    cnt_e            cnt;
    logic [CntW-1:0] cnt_val;
    cond_e           cond;
    logic [PcW-1:0]  target;
  } uword_t;

  localparam logic [PcW-1:0] PcIdle = 4'd0;
  localparam logic [PcW-1:0] PcDay  = 4'd1;
  localparam logic [PcW-1:0] PcHour = 4'd3;
  localparam logic [PcW-1:0] PcMin  = 4'd5;
  localparam logic [PcW-1:0] PcYear = 4'd7;
  localparam logic [PcW-1:0] PcMon  = 4'd9;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{OP_LOAD, DIV_DAY, CNT_HOLD, '0, C_ALWAYS, PcIdle};
    case (pc)
      4'd0:  w = '{OP_LOAD,      DIV_DAY,  CNT_LOAD, 4'd15, C_IDLE,   PcIdle};
      4'd1:  w = '{OP_DSTEP,     DIV_DAY,  CNT_DEC,  4'd0,  C_CNT_NZ, PcDay};
      4'd2:  w = '{OP_SAVE_DAYS, DIV_DAY,  CNT_LOAD, 4'd4,  C_NEXT,   PcIdle};
      4'd3:  w = '{OP_DSTEP,     DIV_HOUR, CNT_DEC,  4'd0,  C_CNT_NZ, PcHour};
      4'd4:  w = '{OP_SAVE_HOUR, DIV_DAY,  CNT_LOAD, 4'd5,  C_NEXT,   PcIdle};
      4'd5:  w = '{OP_DSTEP,     DIV_MIN,  CNT_DEC,  4'd0,  C_CNT_NZ, PcMin};
      4'd6:  w = '{OP_SAVE_MIN,  DIV_DAY,  CNT_HOLD, 4'd0,  C_NEXT,   PcIdle};
      4'd7:  w = '{OP_YSTEP,     DIV_DAY,  CNT_HOLD, 4'd0,  C_YGE,    PcYear};
      4'd8:  w = '{OP_SAVE_YDAY, DIV_DAY,  CNT_HOLD, 4'd0,  C_NEXT,   PcIdle};
      4'd9:  w = '{OP_MSTEP,     DIV_DAY,  CNT_HOLD, 4'd0,  C_MGE,    PcMon};
      4'd10: w = '{OP_DONE,      DIV_DAY,  CNT_HOLD, 4'd0,  C_ALWAYS, PcIdle};
      default: w = '{OP_LOAD,    DIV_DAY,  CNT_HOLD, 4'd0,  C_ALWAYS, PcIdle};
    endcase
    return w;
  endfunction

  // Years since 1900; exact for the whole 8-bit range (1900 and 2100 are not leap).
  function automatic logic is_leap(input logic [YearW-1:0] yq);
    return (yq[1:0] == 2'b00) && (yq != '0) && (yq != Year2100);
  endfunction

  function automatic logic [YdayW-1:0] year_len(input logic [YearW-1:0] yq);
    return is_leap(yq) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [MdayW-1:0] month_len(input logic [MonW-1:0] m,
                                                 input logic leap);
    logic [MdayW-1:0] d;
    case (m)
      4'd1:                    d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // (days + 4) mod 7 by octal digit sums, since 8 is 1 mod 7.
  function automatic logic [WdayW-1:0] weekday_of(input logic [DaysW-1:0] days);
    logic [17:0] x;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  r;
    x  = {2'b00, days} + 18'd4;
    s1 = '0;
    for (int i = 0; i < 6; i++) begin
      s1 = s1 + {3'b000, x[3*i +: 3]};
    end
    s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
    if (s2 >= 4'd14) begin
      r = s2 - 4'd14;
    end else if (s2 >= {1'b0, DaysPerWk}) begin
      r = s2 - {1'b0, DaysPerWk};
    end else begin
      r = s2;
    end
    return r[WdayW-1:0];
  endfunction

endpackage

@@ hdl/epoch_seconds_to_utc_date.sv @@
// Unix epoch seconds to broken-down UTC date, run by a microcoded sequencer.
// Depends on e2utc_pkg (microcode ROM, calendar functions, types).
`timescale 1ns / 1ps

//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-------------------------
//  command  | epoch_seconds_i                               | start && !busy
//  result   | second_o minute_o hour_o weekday_o            | valid_o, one cycle
//           | years_since_1900_o day_of_year_o month_o      |
//           | day_of_month_o                                |
//
//  Time from accepted start to valid_o grows with Y = years past 1970 (0..136)
//  and M = month index (0..11), through the year and month subtraction loops.
//  A new command may be issued in the cycle valid_o is high.
//  rst_ni clears the step counter and strobe; results hold no reset value.
//  The receiver cannot stall; each result is shown exactly once.

module epoch_seconds_to_utc_date (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [e2utc_pkg::SecW-1:0]     epoch_seconds_i,
  output logic                           valid_o,
  output logic [e2utc_pkg::MinW-1:0]     second_o,
  output logic [e2utc_pkg::MinW-1:0]     minute_o,
  output logic [e2utc_pkg::HourW-1:0]    hour_o,
  output logic [e2utc_pkg::WdayW-1:0]    weekday_o,
  output logic [e2utc_pkg::YearW-1:0]    years_since_1900_o,
  output logic [e2utc_pkg::YdayW-1:0]    day_of_year_o,
  output logic [e2utc_pkg::MonW-1:0]     month_o,
  output logic [e2utc_pkg::MdayW-1:0]    day_of_month_o
);
  import e2utc_pkg::*;

  logic [PcW-1:0]   pc_q, pc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [SecW-1:0]  acc_q;
  logic [DaysW-1:0] quo_q;
  logic [DaysW-1:0] days_q;
  logic [YearW-1:0] year_q;
  logic [MonW-1:0]  mon_q;
  logic [YdayW-1:0] yday_q;
  logic [HourW-1:0] hour_q;
  logic [MinW-1:0]  min_q;
  logic [MinW-1:0]  sec_q;
  logic [WdayW-1:0] wday_q;

  uword_t           uw;
  logic [SecW-1:0]  dvs;
  logic             dge;
  logic             yge;
  logic             mge;
  logic             jump;
  logic [MdayW-1:0] mlen;

  assign uw = ucode(pc_q);

  always_comb begin
    case (uw.dsel)
      DIV_HOUR: dvs = SecPerHour << cnt_q;
      DIV_MIN:  dvs = SecPerMin << cnt_q;
      default:  dvs = SecPerDay << cnt_q;
    endcase
  end

  assign dge  = acc_q >= dvs;
  assign yge  = days_q >= {{(DaysW-YdayW){1'b0}}, year_len(year_q)};
  assign mlen = month_len(mon_q, is_leap(year_q));
  assign mge  = (mon_q < LastMonth) && (days_q >= {{(DaysW-MdayW){1'b0}}, mlen});

  always_comb begin
    case (uw.cond)
      C_ALWAYS: jump = 1'b1;
      C_IDLE:   jump = !start;
      C_CNT_NZ: jump = cnt_q != '0;
      C_YGE:    jump = yge;
      C_MGE:    jump = mge;
      default:  jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + 1'b1;

    case (uw.cnt)
      CNT_LOAD: cnt_d = uw.cnt_val;
      CNT_DEC:  cnt_d = cnt_q - 1'b1;
      default:  cnt_d = cnt_q;
    endcase

    done_d = uw.op == OP_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PcIdle;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_LOAD: begin
        acc_q <= epoch_seconds_i;
        quo_q <= '0;
      end
      OP_DSTEP: begin
        if (dge) begin
          acc_q <= acc_q - dvs;
        end
        quo_q <= {quo_q[DaysW-2:0], dge};
      end
      OP_SAVE_DAYS: begin
        days_q <= quo_q;
        quo_q  <= '0;
      end
      OP_SAVE_HOUR: begin
        hour_q <= quo_q[HourW-1:0];
        quo_q  <= '0;
      end
      OP_SAVE_MIN: begin
        min_q  <= quo_q[MinW-1:0];
        sec_q  <= acc_q[MinW-1:0];
        wday_q <= weekday_of(days_q);
        year_q <= FirstYear;
      end
      OP_YSTEP: begin
        if (yge) begin
          days_q <= days_q - {{(DaysW-YdayW){1'b0}}, year_len(year_q)};
          year_q <= year_q + 1'b1;
        end
      end
      OP_SAVE_YDAY: begin
        yday_q <= days_q[YdayW-1:0];
        mon_q  <= '0;
      end
      OP_MSTEP: begin
        if (mge) begin
          days_q <= days_q - {{(DaysW-MdayW){1'b0}}, mlen};
          mon_q  <= mon_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy               = pc_q != PcIdle;
  assign valid_o            = done_q;
  assign second_o           = sec_q;
  assign minute_o           = min_q;
  assign hour_o             = hour_q;
  assign weekday_o          = wday_q;
  assign years_since_1900_o = year_q;
  assign day_of_year_o      = yday_q;
  assign month_o            = mon_q;
  assign day_of_month_o     = days_q[MdayW-1:0] + 1'b1;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe repeated");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_o <= LastMonth && day_of_month_o != '0))
    else $error("date out of range");

endmodule
